/* hdl/thd_pkg.sv */
// ----------------------------------------------------------------------------
// thd_pkg: shared types and constants
// Beat payloads, the run summary passed from front to back, and the
// fixed-point constants of the dB-to-amplitude and result paths.
// ----------------------------------------------------------------------------
package thd_pkg;

  typedef struct packed {
    logic signed [15:0] level_db;
    logic               last_level;
  } level_beat_t;

  typedef struct packed {
    logic [31:0] thd_percent;
    logic        status;
  } thd_beat_t;

  // One finished run: Q12.52 square sum, Q4.28 fundamental, saturation seen
  typedef struct packed {
    logic [63:0] square_sum;
    logic [31:0] fundamental;
    logic        saturated;
  } run_summary_t;

  localparam logic [29:0] LOG2_10_Q40 = 30'd713378626;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [24:0] SCALE_OUT   = 25'd26214400;
  localparam logic [47:0] EXP_BIAS    = 48'h2000_0000_0000;  // 32 in Q40
  localparam logic [7:0]  N_SAT_CODE  = 8'd36;               // biased n = 4
  localparam logic [3:0]  EXP_TERMS   = 4'd13;

  // Divide a 32-bit series term by its index (1..13), truncating.
  // Multiply by ceil(2^36 / k) and drop 36 bits: exact for any 32-bit term.
  function automatic logic [32:0] div_by_index(input logic [31:0] x,
                                               input logic [3:0] k);
    logic [35:0] recip;
    logic [67:0] prod;
    logic [32:0] q;
    unique case (k)
      4'd2:    recip = 36'd34359738368;
      4'd3:    recip = 36'd22906492246;
      4'd4:    recip = 36'd17179869184;
      4'd5:    recip = 36'd13743895348;
      4'd6:    recip = 36'd11453246123;
      4'd7:    recip = 36'd9817068106;
      4'd8:    recip = 36'd8589934592;
      4'd9:    recip = 36'd7635497416;
      4'd10:   recip = 36'd6871947674;
      4'd11:   recip = 36'd6247225158;
      4'd12:   recip = 36'd5726623062;
      4'd13:   recip = 36'd5286113596;
      default: recip = 36'd0;
    endcase
    prod = {36'd0, x} * {32'd0, recip};
    if (k <= 4'd1) q = {1'b0, x};
    else q = {1'b0, prod[67:36]};
    return q;
  endfunction

endpackage

/* hdl/thd_front.sv */
// ----------------------------------------------------------------------------
// thd_front: level intake and square accumulation
// Converts each dB level to a Q4.28 amplitude with a Taylor series for
// 2^f (one multiply and one divide per term), keeps the fundamental, sums
// the squares of the rest, and pushes a run summary when the run closes.
// ----------------------------------------------------------------------------
module thd_front import thd_pkg::*; #(
  parameter int MAX_LEVELS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  level_beat_t  in_item,
  output logic         push,
  output run_summary_t push_data,
  input  logic         queue_full
);

  localparam int CW = $clog2(MAX_LEVELS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXP0 = 3'd1;
  localparam logic [2:0] S_EXP1 = 3'd2;
  localparam logic [2:0] S_TMUL = 3'd3;
  localparam logic [2:0] S_TDIV = 3'd4;
  localparam logic [2:0] S_AMP  = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_PUSH = 3'd7;

  logic [2:0]         state;
  logic [CW-1:0]      count;
  logic               first;
  logic               sat;
  logic [31:0]        fund;
  logic [63:0]        sum;
  logic signed [15:0] level;
  logic               last;
  logic signed [46:0] e_prod;
  logic [7:0]         n_code;
  logic [31:0]        y;
  logic [32:0]        t;
  logic [33:0]        m;
  logic [63:0]        t_prod;
  logic [3:0]         k;
  logic [63:0]        sq_prod;

  logic [47:0] ue;
  logic [63:0] f_prod;
  logic [32:0] q;
  logic [5:0]  shamt;
  logic [33:0] m_shift;
  logic [31:0] amp;
  logic        amp_sat;
  logic [64:0] acc;

  assign in_ready  = (state == S_IDLE);
  assign push      = (state == S_PUSH) && !queue_full;
  assign push_data = '{square_sum: sum, fundamental: fund, saturated: sat};

  always_comb begin
    ue      = {e_prod[46], e_prod} + EXP_BIAS;
    f_prod  = ue[39:8] * LN2_Q32;
    q       = div_by_index(t_prod[63:32], k);
    amp_sat = (n_code >= N_SAT_CODE);
    shamt   = 6'(N_SAT_CODE - n_code);
    m_shift = m >> shamt;
    amp     = amp_sat ? 32'hFFFF_FFFF : m_shift[31:0];
    acc     = {1'b0, sum} + {5'd0, sq_prod[63:4]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      first <= 1'b1;
      sat   <= 1'b0;
      fund  <= '0;
      sum   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            level <= in_item.level_db;
            last  <= in_item.last_level;
            if (count < CW'(MAX_LEVELS)) begin
              state <= S_EXP0;
            end else if (in_item.last_level) begin
              state <= S_PUSH;
            end
          end
        end
        S_EXP0: begin
          e_prod <= level * $signed({1'b0, LOG2_10_Q40});
          state  <= S_EXP1;
        end
        S_EXP1: begin
          n_code <= ue[47:40];
          y      <= f_prod[63:32];
          t      <= 33'h1_0000_0000;
          m      <= 34'h1_0000_0000;
          k      <= 4'd1;
          state  <= S_TMUL;
        end
        S_TMUL: begin
          t_prod <= t * y;
          state  <= S_TDIV;
        end
        S_TDIV: begin
          t <= q;
          m <= m + {1'b0, q};
          if (k == EXP_TERMS) begin
            state <= S_AMP;
          end else begin
            k     <= k + 4'd1;
            state <= S_TMUL;
          end
        end
        S_AMP: begin
          if (amp_sat) sat <= 1'b1;
          if (first) begin
            fund  <= amp;
            first <= 1'b0;
            count <= count + 1'b1;
            state <= last ? S_PUSH : S_IDLE;
          end else begin
            sq_prod <= amp * amp;
            state   <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc[64]) begin
            sum <= 64'hFFFF_FFFF_FFFF_FFFF;
            sat <= 1'b1;
          end else begin
            sum <= acc[63:0];
          end
          count <= count + 1'b1;
          state <= last ? S_PUSH : S_IDLE;
        end
        S_PUSH: begin
          // hold until the queue has room, then start a fresh run
          if (!queue_full) begin
            count <= '0;
            first <= 1'b1;
            sat   <= 1'b0;
            fund  <= '0;
            sum   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/thd_queue.sv */
// ----------------------------------------------------------------------------
// thd_queue: two-entry run summary queue
// Decouples the level front from the result back.
// ----------------------------------------------------------------------------
module thd_queue import thd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  run_summary_t push_data,
  output logic         full,
  input  logic         pop,
  output run_summary_t pop_data,
  output logic         not_empty
);

  run_summary_t mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/thd_back.sv */
// ----------------------------------------------------------------------------
// thd_back: distortion result
// Square root of the sum (two bits a cycle), scale by 100 * 2^18, then a
// restoring divide by the fundamental (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module thd_back import thd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  run_summary_t q_data,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output thd_beat_t    out_item
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQRT = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]  state;
  logic [5:0]  iter;
  logic [63:0] x;
  logic [33:0] rem;
  logic [31:0] root;
  logic [31:0] fund;
  logic        st;
  logic [56:0] dvd;
  logic [32:0] drem;
  logic [56:0] quot;
  logic [31:0] thd;

  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic [32:0] drem_sh;

  always_comb begin
    rem_sh  = {rem[31:0], x[63:62]};
    trial   = {root, 2'b01};
    drem_sh = {drem[31:0], dvd[56]};
  end

  assign pop = (state == B_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != B_OUT) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            x    <= q_data.square_sum;
            fund <= q_data.fundamental;
            st   <= q_data.saturated;
            rem  <= '0;
            root <= '0;
            quot <= '0;
            iter <= 6'd31;
            if (q_data.square_sum == 64'd0) begin
              thd   <= '0;
              state <= B_OUT;
            end else if (q_data.fundamental == 32'd0) begin
              thd   <= 32'hFFFF_FFFF;
              st    <= 1'b1;
              state <= B_OUT;
            end else begin
              state <= B_SQRT;
            end
          end
        end
        B_SQRT: begin
          x <= {x[61:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[30:0], 1'b0};
          end
          if (iter == 6'd0) state <= B_MUL;
          else iter <= iter - 6'd1;
        end
        B_MUL: begin
          dvd   <= root * SCALE_OUT;
          drem  <= '0;
          quot  <= '0;
          iter  <= 6'd56;
          state <= B_DIV;
        end
        B_DIV: begin
          dvd <= {dvd[55:0], 1'b0};
          if (drem_sh >= {1'b0, fund}) begin
            drem <= drem_sh - {1'b0, fund};
            quot <= {quot[55:0], 1'b1};
          end else begin
            drem <= drem_sh;
            quot <= {quot[55:0], 1'b0};
          end
          if (iter == 6'd0) state <= B_OUT;
          else iter <= iter - 6'd1;
          if (iter == 6'd0) begin
            thd <= '0;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (quot[56:32] != 25'd0) begin
              out_item <= '{thd_percent: 32'hFFFF_FFFF, status: 1'b1};
            end else if (thd != 32'd0) begin
              out_item <= '{thd_percent: thd, status: st};
            end else begin
              out_item <= '{thd_percent: quot[31:0], status: st};
            end
            quot  <= '0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* hdl/thd_from_harmonic_levels.sv */
// ----------------------------------------------------------------------------
// thd_from_harmonic_levels: total harmonic distortion from dB levels
// Top level: front, run summary queue, back, and output register.
// ----------------------------------------------------------------------------
// Send a run of Q8.8 dB levels, fundamental first, last one marked; one
// beat comes out per run with the distortion in percent (Q16.16) and a
// saturation status. In the front the 2^f series evaluates each term
// through one multiplier and a reciprocal multiply (a multiply state and a
// divide state per term); the fundamental then skips the accumulate, while
// every other level is squared and accumulated. Levels past MAX_LEVELS in
// a run are dropped without conversion. The back takes a run through an
// intake state, 32 square root steps, one scale multiply, 57 divide steps
// and a result state, and runs alongside the front, so the front can work
// on the next run while the back finishes the last one.
// ----------------------------------------------------------------------------
module thd_from_harmonic_levels import thd_pkg::*; #(
  parameter int MAX_LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  level_beat_t in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output thd_beat_t   out_item
);

  logic         push;
  run_summary_t push_data;
  logic         queue_full;
  logic         pop;
  run_summary_t pop_data;
  logic         queue_valid;

  // Convert levels and accumulate the run
  thd_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  // Hold finished runs so the front can start the next one
  thd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (queue_valid)
  );

  // Root, scale and divide; result beat leaves through a register
  thd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (queue_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* hdl/thd_checker.sv */
// ----------------------------------------------------------------------------
// thd_checker: port-level checks
// Watches the top level ports; bound to every instance.
// ----------------------------------------------------------------------------
module thd_checker import thd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input level_beat_t in_item,
  input logic        out_valid,
  input logic        out_ready,
  input thd_beat_t   out_item
);

  // a result beat holds until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat dropped or changed while stalled");

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // a closing level always leaves the front busy in the cycle after it is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.last_level |=> !in_ready)
    else $error("front took a beat right after a closing level");

  // a result never appears in the cycle right after reset released
  assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid)
    else $error("result beat with no run behind it");

endmodule

bind thd_from_harmonic_levels thd_checker u_thd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
